// ===== hdl/emms_pkg.sv =====
`timescale 1ns / 1ps

package emms_pkg;

	localparam int ELAPSED_WIDTH = 17;
	localparam int CMP_WIDTH = (ELAPSED_WIDTH > 16) ? ELAPSED_WIDTH : 16;
	localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

	localparam int ADDR_WIDTH = 4;
	localparam int DATA_WIDTH = 32;

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_TIMEOUT   = 2'd0;
	localparam logic [1:0] REG_FAST_DUTY = 2'd1;
	localparam logic [1:0] REG_SLOW_DUTY = 2'd2;

	localparam logic [15:0] TIMEOUT_RESET   = 16'd35000;
	localparam logic [7:0]  FAST_DUTY_RESET = 8'd230;
	localparam logic [7:0]  SLOW_DUTY_RESET = 8'd140;

	localparam logic       OP_TICK = 1'b0;
	localparam logic       OP_MOVE = 1'b1;
	localparam logic [1:0] DIR_UP      = 2'd0;
	localparam logic [1:0] DIR_DESCEND = 2'd1;

	localparam logic [1:0] MOTION_IDLE = 2'd0;
	localparam logic [1:0] MOTION_DOWN = 2'd1;
	localparam logic [1:0] MOTION_UP   = 2'd2;

	localparam logic [1:0] CODE_ACK_BOTTOM = 2'd0;
	localparam logic [1:0] CODE_ACK_TOP    = 2'd1;
	localparam logic [1:0] CODE_SHIELD     = 2'd2;
	localparam logic [1:0] CODE_TIMEOUT    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DOWN = 3'b010,
		ST_UP   = 3'b100
	} move_state_t;

	typedef struct packed {
		logic       operation;
		logic [1:0] direction;
		logic       reply_wanted;
		logic       bottom_a;
		logic       bottom_b;
		logic       top_a;
		logic       top_b;
		logic       shield_closed;
	} item_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  fast_duty;
		logic [7:0]  slow_duty;
	} cfg_t;

	typedef struct packed {
		move_state_t              mstate;
		logic                     reply_flag;
		logic [7:0]               duty;
		logic                     bridge_one;
		logic                     bridge_two;
		logic [ELAPSED_WIDTH-1:0] elapsed;
	} seq_state_t;

	typedef struct packed {
		logic [7:0] motor_duty;
		logic       drive_in1;
		logic       drive_in2;
		logic [1:0] motion;
		logic       reply_valid;
		logic [1:0] reply_code;
	} result_t;

endpackage

// ===== hdl/emms_step.sv =====
`timescale 1ns / 1ps

module emms_step (
	input  emms_pkg::seq_state_t cur,
	input  emms_pkg::item_t      item,
	input  emms_pkg::cfg_t       cfg,
	output emms_pkg::seq_state_t nxt,
	output emms_pkg::result_t    res
);
	import emms_pkg::*;

	logic                     rv;
	logic [1:0]               code;
	logic [ELAPSED_WIDTH-1:0] elapsed_inc;
	logic                     bottom_both;
	logic                     top_both;
	logic                     one_hit;
	logic                     both_hit;

	assign elapsed_inc = (cur.elapsed != ELAPSED_MAX) ?
		cur.elapsed + ELAPSED_WIDTH'(1) : cur.elapsed;
	assign bottom_both = item.bottom_a && item.bottom_b;
	assign top_both    = item.top_a && item.top_b;
	assign one_hit  = (cur.mstate == ST_DOWN) ? (item.bottom_a || item.bottom_b) :
		(item.top_a || item.top_b);
	assign both_hit = (cur.mstate == ST_DOWN) ? bottom_both : top_both;

	always_comb begin
		nxt  = cur;
		rv   = 1'b0;
		code = CODE_ACK_BOTTOM;
		if (item.operation == OP_MOVE) begin
			if (cur.mstate == ST_IDLE) begin
				nxt.reply_flag = item.reply_wanted;
				if (item.direction == DIR_DESCEND) begin
					if (bottom_both) begin
						rv   = item.reply_wanted;
						code = CODE_ACK_BOTTOM;
					end else begin
						nxt.bridge_one = 1'b0;
						nxt.bridge_two = 1'b1;
						nxt.duty       = cfg.fast_duty;
						nxt.mstate     = ST_DOWN;
						nxt.elapsed    = '0;
					end
				end else if (item.direction == DIR_UP) begin
					if (!item.shield_closed) begin
						rv   = item.reply_wanted;
						code = CODE_SHIELD;
					end else if (top_both) begin
						rv   = item.reply_wanted;
						code = CODE_ACK_TOP;
					end else begin
						nxt.bridge_one = 1'b1;
						nxt.bridge_two = 1'b0;
						nxt.duty       = cfg.fast_duty;
						nxt.mstate     = ST_UP;
						nxt.elapsed    = '0;
					end
				end
			end
		end else begin
			nxt.elapsed = elapsed_inc;
			if (cur.mstate != ST_IDLE) begin
				if (one_hit) begin
					nxt.duty = cfg.slow_duty;
				end
				if (both_hit) begin
					nxt.duty   = '0;
					nxt.mstate = ST_IDLE;
					rv         = cur.reply_flag;
					code       = (cur.mstate == ST_DOWN) ? CODE_ACK_BOTTOM : CODE_ACK_TOP;
				end else if (CMP_WIDTH'(elapsed_inc) > CMP_WIDTH'(cfg.timeout_ticks)) begin
					nxt.duty   = '0;
					nxt.mstate = ST_IDLE;
					rv         = cur.reply_flag;
					code       = CODE_TIMEOUT;
				end
			end
		end
	end

	always_comb begin
		res.motor_duty  = nxt.duty;
		res.drive_in1   = nxt.bridge_one;
		res.drive_in2   = nxt.bridge_two;
		unique case (nxt.mstate)
			ST_DOWN: res.motion = MOTION_DOWN;
			ST_UP:   res.motion = MOTION_UP;
			default: res.motion = MOTION_IDLE;
		endcase
		res.reply_valid = rv;
		res.reply_code  = rv ? code : CODE_ACK_BOTTOM;
	end

endmodule

// ===== hdl/endstop_motor_move_sequencer_unit.sv =====
`timescale 1ns / 1ps

// Plate move sequencer: drives a motor bridge between bottom and top end sensors.
// Input channel (in_valid / in_stall) carries one request per item: either a
// one millisecond tick (operation 0) or a move command (operation 1) together
// with the current sensor and shield levels.
// Output channel (out_valid / out_stall) returns exactly one result per request:
// motor duty, bridge inputs, motion state and an optional reply with its code.
// Path: an accepted request is held in the input register; the step logic then
// computes the state update, which lands in the result register with the result.
// Throughput: one request per cycle unless out_stall holds it; input and result
// registers keep both sides moving, set by the single step-logic state update.
// Receiver stall: the result register holds; the input register fills and then
// in_stall rises until the result is taken. No request is lost or repeated.
// Reset (arst_n low): state to motion idle, duty 0, bridge inputs low, elapsed count 0,
// reply flag 0, registers back to timeout 35000, fast duty 230, slow duty 140.
// Configuration: APB-style port, timeout at 0x0, fast duty at 0x4, slow duty at
// 0x8; write only while no request is in flight.
module endstop_motor_move_sequencer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [1:0]                         direction,
	input  logic                               reply_wanted,
	input  logic                               bottom_a,
	input  logic                               bottom_b,
	input  logic                               top_a,
	input  logic                               top_b,
	input  logic                               shield_closed,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         motor_duty,
	output logic                               drive_in1,
	output logic                               drive_in2,
	output logic [1:0]                         motion,
	output logic                               reply_valid,
	output logic [1:0]                         reply_code,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [emms_pkg::ADDR_WIDTH-1:0]    paddr,
	input  logic [emms_pkg::DATA_WIDTH-1:0]    pwdata,
	output logic [emms_pkg::DATA_WIDTH-1:0]    prdata,
	output logic                               pready
);
	import emms_pkg::*;

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	item_t      item_in;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_nxt;
	result_t    res_q;
	logic       out_valid_q;
	logic       res_free;
	logic       advance;
	logic       cfg_wr;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
			cfg_q.fast_duty     <= FAST_DUTY_RESET;
			cfg_q.slow_duty     <= SLOW_DUTY_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TIMEOUT:   cfg_q.timeout_ticks <= pwdata[15:0];
				REG_FAST_DUTY: cfg_q.fast_duty     <= pwdata[7:0];
				REG_SLOW_DUTY: cfg_q.slow_duty     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TIMEOUT:   prdata = {16'd0, cfg_q.timeout_ticks};
			REG_FAST_DUTY: prdata = {24'd0, cfg_q.fast_duty};
			REG_SLOW_DUTY: prdata = {24'd0, cfg_q.slow_duty};
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Handshake: the result register frees when empty or when taken this
	// cycle; the input stage advances into it then, and refills at once.
	// ---------------------------------------------------------------------
	assign res_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;

	assign item_in.operation     = operation;
	assign item_in.direction     = direction;
	assign item_in.reply_wanted  = reply_wanted;
	assign item_in.bottom_a      = bottom_a;
	assign item_in.bottom_b      = bottom_b;
	assign item_in.top_a         = top_a;
	assign item_in.top_b         = top_b;
	assign item_in.shield_closed = shield_closed;

	// Input register: load on accept, drop once handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer state update and result computation
	// ---------------------------------------------------------------------
	emms_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Commit the state only when the request moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mstate     <= ST_IDLE;
			state_q.reply_flag <= 1'b0;
			state_q.duty       <= '0;
			state_q.bridge_one <= 1'b0;
			state_q.bridge_two <= 1'b0;
			state_q.elapsed    <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign motor_duty  = res_q.motor_duty;
	assign drive_in1   = res_q.drive_in1;
	assign drive_in2   = res_q.drive_in2;
	assign motion      = res_q.motion;
	assign reply_valid = res_q.reply_valid;
	assign reply_code  = res_q.reply_code;

`ifndef NO_ASSERTIONS
	// An idle plate never has the motor powered.
	a_idle_no_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && motion == MOTION_IDLE) |-> (motor_duty == 8'd0))
		else $error("motor duty nonzero while idle");

	// Moving up drives bridge input one only; moving down drives input two only.
	a_bridge_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (motion == MOTION_UP || motion == MOTION_DOWN)) |->
		((drive_in1 == (motion == MOTION_UP)) && (drive_in2 == (motion == MOTION_DOWN))))
		else $error("bridge inputs disagree with motion direction");

	// A stalled request in the input register stays there.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("input register lost a stalled request");

	// The state only changes when a request is handed to the result register.
	a_state_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("sequencer state changed without a request");
`endif

endmodule
